FILE: design/r30rbg_pkg.sv
// ----------------------------------------------------------------------------
// r30rbg_pkg
// Shared constants and types for the Rule 30 ring block generator.
// ----------------------------------------------------------------------------
package r30rbg_pkg;

  // Cells in the ring (8 to 128).
  localparam int CELL_COUNT = 128;
  // Cell number CELL_COUNT / 2, counted from one, sits at index CENTER_IDX.
  localparam int CENTER_IDX = CELL_COUNT / 2 - 1;

  // Seed as carried by the input transaction: cell 1 in the top bit.
  localparam int SEED_W = 128;
  localparam int HALF_W = 64;

  // Generations per block and the width of the generation counter.
  localparam int BLOCK_GENS = 128;
  localparam int GEN_W = $clog2(BLOCK_GENS);

  // Zero detection runs over groups of cells, one register per group.
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_COUNT = (CELL_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

  // Input operation codes.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // Controls from the sequencer to the cell row.
  typedef struct packed {
    logic load;   // take the seed into every cell
    logic check;  // set the center cell when the ring is all zero
    logic step;   // advance one generation
  } ring_ctrl_t;

endpackage

FILE: design/r30rbg_if.sv
// ----------------------------------------------------------------------------
// r30rbg_if
// Valid/ready channels for the seed/command input and the block output.
// ----------------------------------------------------------------------------
interface r30rbg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] seed_upper;
  logic [63:0] seed_lower;

  modport source (output valid, output operation, output seed_upper,
                  output seed_lower, input ready);
  modport sink   (input valid, input operation, input seed_upper,
                  input seed_lower, output ready);
endinterface

interface r30rbg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_upper;
  logic [63:0] block_lower;

  modport source (output valid, output block_upper, output block_lower,
                  input ready);
  modport sink   (input valid, input block_upper, input block_lower,
                  output ready);
endinterface

FILE: design/r30rbg_cell.sv
// ----------------------------------------------------------------------------
// r30rbg_cell
// One Rule 30 cell: holds its bit and computes the next one from neighbors.
// ----------------------------------------------------------------------------
module r30rbg_cell (
  input  logic clk,
  input  logic rst,
  input  logic left,      // cell k-1
  input  logic right,     // cell k+1
  input  logic load_en,
  input  logic load_bit,
  input  logic set_en,
  input  logic step_en,
  output logic q,
  output logic nxt
);

  // Rule 30: right XOR (self OR left).
  assign nxt = right ^ (q | left);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (load_en) begin
      q <= load_bit;
    end else if (set_en) begin
      q <= 1'b1;
    end else if (step_en) begin
      q <= nxt;
    end
  end

endmodule

FILE: design/r30rbg_ring.sv
// ----------------------------------------------------------------------------
// r30rbg_ring
// Circular row of Rule 30 cells with a registered all-zero detector.
// ----------------------------------------------------------------------------
module r30rbg_ring (
  input  logic                            clk,
  input  logic                            rst,
  input  r30rbg_pkg::ring_ctrl_t          ctrl,
  input  logic [r30rbg_pkg::SEED_W-1:0]   seed,
  output logic                            center_next
);

  logic [r30rbg_pkg::CELL_COUNT-1:0]  cells;
  logic [r30rbg_pkg::CELL_COUNT-1:0]  cells_nxt;
  logic [r30rbg_pkg::GROUP_COUNT-1:0] grp_any;
  logic [r30rbg_pkg::GROUP_COUNT-1:0] grp_any_next;
  logic                               ring_zero;

  for (genvar k = 0; k < r30rbg_pkg::CELL_COUNT; k++) begin : g_cell
    localparam int UP   = (k + 1 == r30rbg_pkg::CELL_COUNT) ? 0 : k + 1;
    localparam int DOWN = (k == 0) ? r30rbg_pkg::CELL_COUNT - 1 : k - 1;

    r30rbg_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .left     (cells[DOWN]),
      .right    (cells[UP]),
      .load_en  (ctrl.load),
      .load_bit (seed[r30rbg_pkg::SEED_W-1-k]),
      .set_en   (ctrl.check && ring_zero && (k == r30rbg_pkg::CENTER_IDX)),
      .step_en  (ctrl.step),
      .q        (cells[k]),
      .nxt      (cells_nxt[k])
    );
  end

  // Group OR, registered every cycle; the top OR reads the registers.
  for (genvar g = 0; g < r30rbg_pkg::GROUP_COUNT; g++) begin : g_grp
    always_comb begin
      grp_any_next[g] = 1'b0;
      for (int j = 0; j < r30rbg_pkg::GROUP_SIZE; j++) begin
        if (g * r30rbg_pkg::GROUP_SIZE + j < r30rbg_pkg::CELL_COUNT) begin
          grp_any_next[g] = grp_any_next[g] | cells[g * r30rbg_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
  end

  assign ring_zero   = ~|grp_any;
  assign center_next = cells_nxt[r30rbg_pkg::CENTER_IDX];

endmodule

FILE: design/rule30_ring_block_generator_core.sv
// A load transaction takes effect at its accept edge and returns nothing.
// A generate transaction runs a zero check, then 128 generations at one per cycle in
// the cell row, then moves its block into the output register, which raises it. The
// next transaction is taken only after that move; a stalled output holds the run in
// its last step.
// Reset (rst, synchronous): ring cleared to zero, sequencer idle, no output pending.
// ----------------------------------------------------------------------------
// rule30_ring_block_generator_core
// Rule 30 ring generator: loads a seed, emits 128-bit center-column blocks.
// ----------------------------------------------------------------------------
module rule30_ring_block_generator_core (
  input  logic           clk,
  input  logic           rst,
  r30rbg_in_if.sink      in_ch,
  r30rbg_out_if.source   out_ch
);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,  // wait for a transaction
    ST_CHECK = 4'b0010,  // seed the center cell if the ring is all zero
    ST_RUN   = 4'b0100,  // one generation per cycle
    ST_FIN   = 4'b1000   // hand the block to the output register
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [r30rbg_pkg::GEN_W-1:0]        gen_count;
  logic [r30rbg_pkg::BLOCK_GENS-1:0]   center_bits;
  logic [r30rbg_pkg::BLOCK_GENS-1:0]   out_block;
  logic                                out_valid;
  logic                                in_fire;
  logic                                fin_load;
  logic                                last_gen;
  logic                                center_next;
  r30rbg_pkg::ring_ctrl_t              ctrl;

  // Accept only in idle; a load finishes at its accept edge, so a pending
  // output does not block it.
  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign last_gen = (gen_count == r30rbg_pkg::GEN_W'(r30rbg_pkg::BLOCK_GENS - 1));
  // Move the finished block out once the output register is free.
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ch.ready);

  // Drive the cell row.
  always_comb begin
    ctrl.load  = in_fire && (in_ch.operation == r30rbg_pkg::OP_LOAD);
    ctrl.check = (state == ST_CHECK);
    ctrl.step  = (state == ST_RUN);
  end

  r30rbg_ring u_ring (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .seed        ({in_ch.seed_upper, in_ch.seed_lower}),
    .center_next (center_next)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_ch.operation == r30rbg_pkg::OP_GENERATE)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_gen) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gen_count <= '0;
    end else begin
      state <= state_next;
      // Count generations; wraps back to zero after the last one.
      if (state == ST_RUN) begin
        gen_count <= gen_count + 1'b1;
      end
    end
  end

  // Shift in the center cell after each generation; generation 1 ends on top.
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      center_bits <= {center_bits[r30rbg_pkg::BLOCK_GENS-2:0], center_next};
    end
  end

  // Output register: holds the block until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_block <= center_bits;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.block_upper = out_block[r30rbg_pkg::BLOCK_GENS-1:r30rbg_pkg::HALF_W];
  assign out_ch.block_lower = out_block[r30rbg_pkg::HALF_W-1:0];

endmodule

FILE: design/r30rbg_chk.sv
// ----------------------------------------------------------------------------
// r30rbg_chk
// Port-level checks for the Rule 30 block generator, bound to the top level.
// ----------------------------------------------------------------------------
module r30rbg_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_block_upper,
  input logic [63:0] out_block_lower
);

  // Hold a stalled block steady.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_block_upper)
                                && $stable(out_block_lower))
    else $error("output block changed while stalled");

  // A generate transaction keeps the input closed while the ring runs.
  a_gen_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_operation |=> !in_ready)
    else $error("input accepted during generation");

  // A load never produces a block.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_operation && !out_valid |=> !out_valid)
    else $error("block produced by a load");

  // A new block appears only at the end of a run, never straight from idle.
  a_out_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("block appeared without a run");

endmodule

bind rule30_ring_block_generator_core r30rbg_chk u_r30rbg_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_operation    (in_ch.operation),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_block_upper (out_ch.block_upper),
  .out_block_lower (out_ch.block_lower)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Rule 30 ring block generator. Seed loads and
// block requests go in through the input channel. A cycle-free model of the
// ring runs beside the block and predicts every 128-bit block. Each block
// that comes out is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int HOLDOFF_CYCLES = 800;   // long receiver hold-off, well past one block
  localparam int DRAIN_CYCLES   = 140;   // one block latency plus margin
  localparam int MAX_REPORTS    = 20;

  typedef struct {
    logic        op;
    logic [63:0] upper;
    logic [63:0] lower;
  } seed_cmd_t;

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
  } block_t;

  logic clk;
  logic rst;

  r30rbg_in_if  in_ch ();
  r30rbg_out_if out_ch ();

  rule30_ring_block_generator_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Commands waiting for the driver, and blocks the ring model says must come out.
  seed_cmd_t cmd_queue[$];
  block_t    pending_blocks[$];

  // Ring model: bit k holds cell k+1, so cell 1 sits at bit 0.
  logic [r30rbg_pkg::CELL_COUNT-1:0] ring_model;

  int error_count    = 0;
  int loads_taken    = 0;
  int gens_taken     = 0;
  int blocks_checked = 0;
  bit in_taken       = 1'b0;

  // Clock: 10 ns period, first rising edge at 5 ns.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Ring model
  // --------------------------------------------------------------------------

  // One Rule 30 generation over the whole ring, indices wrapping round.
  function automatic logic [r30rbg_pkg::CELL_COUNT-1:0] ring_step(
      input logic [r30rbg_pkg::CELL_COUNT-1:0] r);
    logic [r30rbg_pkg::CELL_COUNT-1:0] nxt;
    for (int k = 0; k < r30rbg_pkg::CELL_COUNT; k++)
      nxt[k] = r[(k + 1) % r30rbg_pkg::CELL_COUNT]
               ^ (r[k] | r[(k + r30rbg_pkg::CELL_COUNT - 1) % r30rbg_pkg::CELL_COUNT]);
    return nxt;
  endfunction

  // Apply one accepted transaction to the ring model; a generate queues its block.
  task automatic apply_command(input logic op, input logic [63:0] su, input logic [63:0] sl);
    logic [r30rbg_pkg::SEED_W-1:0]     seed_bits;
    logic [r30rbg_pkg::BLOCK_GENS-1:0] gen_bits;
    block_t                            blk;
    if (op == r30rbg_pkg::OP_LOAD) begin
      // Cell n comes from seed bit SEED_W-n; cells beyond a small ring drop out.
      seed_bits = {su, sl};
      for (int k = 0; k < r30rbg_pkg::CELL_COUNT; k++)
        ring_model[k] = seed_bits[r30rbg_pkg::SEED_W-1-k];
      loads_taken++;
    end else begin
      // An empty ring would stay empty forever: seed the center cell first.
      if (ring_model == '0)
        ring_model[r30rbg_pkg::CENTER_IDX] = 1'b1;
      // Generation 1 lands in the top bit; the final state stays as the next seed.
      for (int g = 0; g < r30rbg_pkg::BLOCK_GENS; g++) begin
        ring_model = ring_step(ring_model);
        gen_bits[r30rbg_pkg::BLOCK_GENS-1-g] = ring_model[r30rbg_pkg::CENTER_IDX];
      end
      blk.upper = gen_bits[r30rbg_pkg::BLOCK_GENS-1 -: r30rbg_pkg::HALF_W];
      blk.lower = gen_bits[r30rbg_pkg::HALF_W-1:0];
      pending_blocks.push_back(blk);
      gens_taken++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_cmd(input logic op, input logic [63:0] su,
                                  input logic [63:0] sl);
    seed_cmd_t c;
    c.op    = op;
    c.upper = su;
    c.lower = sl;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Seed halves: dense random half the time, with zero, all-ones, single-cell and
  // sparse patterns mixed in so the ring starts from very different shapes.
  function automatic logic [63:0] seed_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3, 4:    return rand_word() & rand_word() & rand_word();
      default: return rand_word();
    endcase
  endfunction

  // Sender gaps: often none, usually short, now and then longer than a block
  // so that the gap ends at every phase of the generation run.
  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 6);
      default:    return $urandom_range(7, 160);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of transactions with random gaps, all at the falling edge
  // --------------------------------------------------------------------------
  int        burst_left = 0;
  int        gap_left   = 0;
  seed_cmd_t cur_cmd;

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the offered transaction until the block takes it.
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      cur_cmd = cmd_queue.pop_front();
      in_ch.valid      <= 1'b1;
      in_ch.operation  <= cur_cmd.op;
      in_ch.seed_upper <= cur_cmd.upper;
      in_ch.seed_lower <= cur_cmd.lower;
      // Close the burst after its last transaction and pick the next gap.
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = pick_gap();
      end else begin
        burst_left--;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: stall pattern of its own, plus long hold-offs
  // --------------------------------------------------------------------------
  int          holdoff_left = 0;
  int          holdoff_at   = 6;   // blocks checked before the next hold-off
  int          holdoffs     = 0;
  int          mode_left    = 0;
  int          rx_mode      = 0;
  logic [15:0] rx_cycle     = '0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else if (holdoffs < 2 && blocks_checked >= holdoff_at) begin
      // Refuse blocks for a long stretch while the sender keeps offering,
      // so the block backs up and drops its input ready.
      holdoff_left = HOLDOFF_CYCLES - 1;
      holdoff_at   = holdoff_at + 300;
      holdoffs++;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 600);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;                          // no stalls
        1:       out_ch.ready <= 1'($urandom_range(0, 1));       // coin flip
        2:       out_ch.ready <= ($urandom_range(0, 4) == 0);    // mostly stalled
        default: out_ch.ready <= rx_cycle[2];                    // follows bit 2 of the cycle counter
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: feed the ring model on input transactions, check output blocks
  // --------------------------------------------------------------------------
  block_t exp_blk;

  always @(posedge clk) begin
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (in_taken)
      apply_command(in_ch.operation, in_ch.seed_upper, in_ch.seed_lower);

    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_blocks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected block: expected none actual upper %h lower %h",
                   $time, out_ch.block_upper, out_ch.block_lower);
      end else begin
        exp_blk = pending_blocks.pop_front();
        blocks_checked++;
        if (out_ch.block_upper !== exp_blk.upper) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: block_upper mismatch: expected %h actual %h", $time,
                     exp_blk.upper, out_ch.block_upper);
        end
        if (out_ch.block_lower !== exp_blk.lower) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: block_lower mismatch: expected %h actual %h", $time,
                     exp_blk.lower, out_ch.block_lower);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles, %0d blocks still expected",
               $time, WATCHDOG_LIMIT, pending_blocks.size());
      $display("** rule30_ring_block_generator_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic op_pick;

  initial begin
    // Known values on every input before the first edge.
    rst               = 1'b1;
    ring_model        = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = r30rbg_pkg::OP_LOAD;
    in_ch.seed_upper  = '0;
    in_ch.seed_lower  = '0;
    out_ch.ready      = 1'b0;

    // Directed part.
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);     // ring empty after reset
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);     // continue from the kept state
    add_cmd(r30rbg_pkg::OP_LOAD, '0, '0);         // explicit all-zero seed
    add_cmd(r30rbg_pkg::OP_GENERATE, '1, '1);     // zero ring again; seed fields ignored
    add_cmd(r30rbg_pkg::OP_LOAD, '1, '1);         // every cell set
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_LOAD, 64'h8000_0000_0000_0000, '0); // only cell 1
    add_cmd(r30rbg_pkg::OP_GENERATE, rand_word(), rand_word());
    add_cmd(r30rbg_pkg::OP_LOAD, '0, 64'd1);      // only the last cell
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_LOAD, 64'd1, '0);      // only the center cell
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_LOAD, {16{4'hA}}, {16{4'h5}}); // alternating cells in each half
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_LOAD, rand_word(), rand_word()); // overwritten by the next load
    add_cmd(r30rbg_pkg::OP_LOAD, '1, '0);         // upper half set, lower clear
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_GENERATE, '1, '1);     // back to back blocks
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);
    add_cmd(r30rbg_pkg::OP_LOAD, '0, '1);         // lower half set, upper clear
    add_cmd(r30rbg_pkg::OP_GENERATE, '0, '0);

    // Random part: a little over half generates, seeds of every shape.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op_pick = ($urandom_range(0, 99) < 55) ? r30rbg_pkg::OP_GENERATE
                                              : r30rbg_pkg::OP_LOAD;
      if (op_pick == r30rbg_pkg::OP_LOAD && $urandom_range(0, 24) == 0)
        add_cmd(r30rbg_pkg::OP_LOAD, '0, '0);
      else
        add_cmd(op_pick, seed_word(), seed_word());
    end

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every command to be taken, then for every block to arrive.
    while (cmd_queue.size() != 0 || in_ch.valid)
      @(posedge clk);
    while (pending_blocks.size() != 0)
      @(posedge clk);
    // Drain: catch any extra block the design might still push out.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_blocks.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected blocks never arrived", $time, pending_blocks.size());
    end

    $display("Run covered %0d seed loads and %0d block requests; %0d blocks checked,",
             loads_taken, gens_taken, blocks_checked);
    $display("with %0d receiver hold-offs and %0d errors.", holdoffs, error_count);
    if (error_count == 0)
      $display("** rule30_ring_block_generator_core: PASSED **");
    else
      $display("** rule30_ring_block_generator_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
design/r30rbg_pkg.sv
design/r30rbg_if.sv
design/r30rbg_cell.sv
design/r30rbg_ring.sv
design/rule30_ring_block_generator_core.sv
design/r30rbg_chk.sv
tb/testbench.sv
